// ----- design/pmiu_pkg.sv -----
// ----------------------------------------------------------------------------
// pmiu_pkg
// Widths, layout codes, status codes and shared types of the packed matrix
// index unpacker.
// ----------------------------------------------------------------------------
package pmiu_pkg;

   localparam int ROW_W      = 6;
   localparam int WEIGHT_W   = 32;
   localparam int FMT_W      = 4;
   localparam int COUNT_W    = 12;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [FMT_W-1:0] FMT_FULL_MATRIX    = 4'd0;
   localparam logic [FMT_W-1:0] FMT_UPPER_ROW      = 4'd1;
   localparam logic [FMT_W-1:0] FMT_LOWER_ROW      = 4'd2;
   localparam logic [FMT_W-1:0] FMT_UPPER_DIAG_ROW = 4'd3;
   localparam logic [FMT_W-1:0] FMT_LOWER_DIAG_ROW = 4'd4;
   localparam logic [FMT_W-1:0] FMT_UPPER_COL      = 4'd5;
   localparam logic [FMT_W-1:0] FMT_LOWER_COL      = 4'd6;
   localparam logic [FMT_W-1:0] FMT_UPPER_DIAG_COL = 4'd7;
   localparam logic [FMT_W-1:0] FMT_LOWER_DIAG_COL = 4'd8;

   localparam logic [STATUS_W-1:0] STATUS_ENTRY  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXCESS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_FORMAT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT    = 1'd1;

   typedef struct packed {
      logic [FMT_W-1:0]   fmt;
      logic [ROW_W-1:0]   dim;
      logic [COUNT_W-1:0] expect_count;
      logic               lacks_diag;
      logic               restart;
      logic [ROW_W-1:0]   row_start;
      logic [ROW_W-1:0]   col_start;
   } cfg_type;

endpackage

// ----- design/pmiu_req_if.sv -----
// ----------------------------------------------------------------------------
// pmiu_req_if
// Weight channel: valid/ready handshake with one packed-stream weight.
// ----------------------------------------------------------------------------
interface pmiu_req_if;
   import pmiu_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [WEIGHT_W-1:0] edge_weight;
   logic                       final_weight;

   modport source (output valid, output edge_weight, output final_weight, input ready);
   modport sink   (input valid, input edge_weight, input final_weight, output ready);
endinterface

// ----- design/pmiu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pmiu_rsp_if
// Result channel: valid/ready handshake with one matrix entry or flag.
// ----------------------------------------------------------------------------
interface pmiu_rsp_if;
   import pmiu_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ROW_W-1:0]           row;
   logic [ROW_W-1:0]           col;
   logic signed [WEIGHT_W-1:0] value;
   logic [STATUS_W-1:0]        status;
   logic                       last_of_run;

   modport source (output valid, output row, output col, output value, output status,
                   output last_of_run, input ready);
   modport sink   (input valid, input row, input col, input value, input status,
                   input last_of_run, output ready);
endinterface

// ----- design/pmiu_cfg.sv -----
// ----------------------------------------------------------------------------
// pmiu_cfg
// Layout and dimension registers, with the derived matrix dimension,
// expected weight count and start position of the layout.
// ----------------------------------------------------------------------------
module pmiu_cfg #(
   parameter int MAX_NODES = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pmiu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmiu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pmiu_pkg::cfg_type                cfg
);
   import pmiu_pkg::*;

   localparam logic [ROW_W-1:0] MAX_DIM = ROW_W'(MAX_NODES);

   logic [FMT_W-1:0]   fmt_ff, fmt_in;
   logic [ROW_W-1:0]   nodes_ff, nodes_in;
   logic [ROW_W-1:0]   dim;
   logic [COUNT_W-1:0] dim_w;
   logic [COUNT_W-1:0] prod_sq, prod_lo, prod_hi;

   always_comb begin
      fmt_in   = fmt_ff;
      nodes_in = nodes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MATRIX_FORMAT: fmt_in   = csr_wdata[FMT_W-1:0];
            CSR_NODE_COUNT:    nodes_in = csr_wdata[ROW_W-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_FULL_MATRIX;
         nodes_ff <= ROW_W'(1);
      end else begin
         fmt_ff   <= fmt_in;
         nodes_ff <= nodes_in;
      end
   end

   always_comb begin
      if (nodes_ff == '0) begin
         dim = ROW_W'(1);
      end else if (nodes_ff > MAX_DIM) begin
         dim = MAX_DIM;
      end else begin
         dim = nodes_ff;
      end
      dim_w   = COUNT_W'(dim);
      prod_sq = dim_w * dim_w;
      prod_lo = dim_w * (dim_w - COUNT_W'(1));
      prod_hi = dim_w * (dim_w + COUNT_W'(1));
   end

   always_comb begin
      cfg.fmt        = fmt_ff;
      cfg.dim        = dim;
      cfg.restart    = csr_wr_en;
      cfg.lacks_diag = 1'b0;
      unique case (fmt_ff)
         FMT_FULL_MATRIX:
            cfg.expect_count = prod_sq;
         FMT_UPPER_ROW, FMT_LOWER_ROW, FMT_UPPER_COL, FMT_LOWER_COL: begin
            cfg.expect_count = prod_lo >> 1;
            cfg.lacks_diag   = 1'b1;
         end
         FMT_UPPER_DIAG_ROW, FMT_LOWER_DIAG_ROW, FMT_UPPER_DIAG_COL, FMT_LOWER_DIAG_COL:
            cfg.expect_count = prod_hi >> 1;
         default:
            cfg.expect_count = '0;
      endcase
      // start position follows the format in effect after this cycle
      cfg.row_start = ((fmt_in == FMT_LOWER_ROW) || (fmt_in == FMT_LOWER_COL))
                      ? ROW_W'(1) : '0;
      cfg.col_start = ((fmt_in == FMT_UPPER_ROW) || (fmt_in == FMT_UPPER_COL))
                      ? ROW_W'(1) : '0;
   end

endmodule

// ----- design/pmiu_engine.sv -----
// ----------------------------------------------------------------------------
// pmiu_engine
// Input register, position counters, diagonal fill sequencer and result
// register of the packed matrix index unpacker.
// ----------------------------------------------------------------------------
module pmiu_engine (
   input  logic              clock,
   input  logic              reset,
   input  pmiu_pkg::cfg_type cfg,
   pmiu_req_if.sink          req_chan,
   pmiu_rsp_if.source        rsp_chan
);
   import pmiu_pkg::*;

   typedef enum logic [1:0] {
      PH_PRIMARY,
      PH_SHORT,
      PH_FILL
   } phase_type;

   phase_type                  phase_ff;
   logic [ROW_W-1:0]           fill_idx_ff;
   logic                       s1_valid_ff;
   logic signed [WEIGHT_W-1:0] s1_weight_ff;
   logic                       s1_final_ff;
   logic [ROW_W-1:0]           row_ff, col_ff;
   logic [COUNT_W-1:0]         taken_ff;
   logic                       excess_ff;
   logic                       out_valid_ff;
   logic [ROW_W-1:0]           out_row_ff, out_col_ff;
   logic signed [WEIGHT_W-1:0] out_value_ff;
   logic [STATUS_W-1:0]        out_status_ff;
   logic                       out_last_ff;

   logic                       out_free, out_load, item_done, s1_done, stream_end;
   logic                       under, short_end, fill_end, fill_last;
   logic [COUNT_W-1:0]         taken_inc;
   logic [ROW_W:0]             r7, c7, n7, r_adv, c_adv;
   logic [ROW_W-1:0]           res_row, res_col;
   logic signed [WEIGHT_W-1:0] res_value;
   logic [STATUS_W-1:0]        res_status;
   logic                       res_last;

   // advance the position along the layout
   always_comb begin
      r7    = {1'b0, row_ff};
      c7    = {1'b0, col_ff};
      n7    = {1'b0, cfg.dim};
      r_adv = r7;
      c_adv = c7;
      unique case (cfg.fmt)
         FMT_FULL_MATRIX: begin
            c_adv = c7 + 7'd1;
            if (c_adv >= n7) begin
               c_adv = '0;
               r_adv = r7 + 7'd1;
            end
         end
         FMT_UPPER_ROW: begin
            c_adv = c7 + 7'd1;
            if (c_adv >= n7) begin
               r_adv = r7 + 7'd1;
               c_adv = r_adv + 7'd1;
            end
         end
         FMT_LOWER_ROW: begin
            c_adv = c7 + 7'd1;
            if (c_adv >= r7) begin
               r_adv = r7 + 7'd1;
               c_adv = '0;
            end
         end
         FMT_UPPER_DIAG_ROW: begin
            c_adv = c7 + 7'd1;
            if (c_adv >= n7) begin
               r_adv = r7 + 7'd1;
               c_adv = r_adv;
            end
         end
         FMT_LOWER_DIAG_ROW: begin
            c_adv = c7 + 7'd1;
            if (c_adv > r7) begin
               r_adv = r7 + 7'd1;
               c_adv = '0;
            end
         end
         FMT_UPPER_COL: begin
            r_adv = r7 + 7'd1;
            if (r_adv >= c7) begin
               c_adv = c7 + 7'd1;
               r_adv = '0;
            end
         end
         FMT_LOWER_COL: begin
            r_adv = r7 + 7'd1;
            if (r_adv >= n7) begin
               c_adv = c7 + 7'd1;
               r_adv = c_adv + 7'd1;
            end
         end
         FMT_UPPER_DIAG_COL: begin
            r_adv = r7 + 7'd1;
            if (r_adv > c7) begin
               c_adv = c7 + 7'd1;
               r_adv = '0;
            end
         end
         FMT_LOWER_DIAG_COL: begin
            r_adv = r7 + 7'd1;
            if (r_adv >= n7) begin
               c_adv = c7 + 7'd1;
               r_adv = c_adv;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      under     = taken_ff < cfg.expect_count;
      taken_inc = taken_ff + COUNT_W'(1);
      short_end = s1_final_ff && under && (taken_inc < cfg.expect_count);
      fill_end  = s1_final_ff && under && !short_end && !excess_ff && cfg.lacks_diag;
      fill_last = fill_idx_ff == (cfg.dim - ROW_W'(1));

      res_row    = '0;
      res_col    = '0;
      res_value  = '0;
      res_status = STATUS_ENTRY;
      res_last   = 1'b1;
      item_done  = 1'b1;
      unique case (phase_ff)
         PH_PRIMARY: begin
            if (under) begin
               res_row   = row_ff;
               res_col   = col_ff;
               res_value = s1_weight_ff;
            end else begin
               res_status = STATUS_EXCESS;
            end
            res_last  = !(short_end || fill_end);
            item_done = res_last;
         end
         PH_SHORT: begin
            res_status = STATUS_SHORT;
         end
         PH_FILL: begin
            res_row   = fill_idx_ff;
            res_col   = fill_idx_ff;
            res_last  = fill_last;
            item_done = fill_last;
         end
         default: ;
      endcase

      out_free   = !out_valid_ff || rsp_chan.ready;
      out_load   = s1_valid_ff && out_free;
      s1_done    = out_load && item_done;
      stream_end = s1_done && s1_final_ff;
   end

   assign req_chan.ready = !s1_valid_ff || s1_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PRIMARY;
         fill_idx_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s1_weight_ff  <= '0;
         s1_final_ff   <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         taken_ff      <= '0;
         excess_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
         out_value_ff  <= '0;
         out_status_ff <= STATUS_ENTRY;
         out_last_ff   <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            s1_valid_ff  <= 1'b1;
            s1_weight_ff <= req_chan.edge_weight;
            s1_final_ff  <= req_chan.final_weight;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end

         if (out_load) begin
            out_valid_ff  <= 1'b1;
            out_row_ff    <= res_row;
            out_col_ff    <= res_col;
            out_value_ff  <= res_value;
            out_status_ff <= res_status;
            out_last_ff   <= res_last;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end

         // restart the stream on any csr write or after the final result of a matrix
         if (cfg.restart || stream_end) begin
            row_ff    <= cfg.row_start;
            col_ff    <= cfg.col_start;
            taken_ff  <= '0;
            excess_ff <= 1'b0;
         end else if (out_load && (phase_ff == PH_PRIMARY)) begin
            if (under) begin
               row_ff   <= r_adv[ROW_W-1:0];
               col_ff   <= c_adv[ROW_W-1:0];
               taken_ff <= taken_inc;
            end else begin
               excess_ff <= 1'b1;
            end
         end

         if (cfg.restart) begin
            phase_ff <= PH_PRIMARY;
         end else if (out_load) begin
            unique case (phase_ff)
               PH_PRIMARY: begin
                  if (short_end) begin
                     phase_ff <= PH_SHORT;
                  end else if (fill_end) begin
                     phase_ff    <= PH_FILL;
                     fill_idx_ff <= '0;
                  end
               end
               PH_SHORT: begin
                  phase_ff <= PH_PRIMARY;
               end
               PH_FILL: begin
                  fill_idx_ff <= fill_idx_ff + ROW_W'(1);
                  if (fill_last) begin
                     phase_ff <= PH_PRIMARY;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.row         = out_row_ff;
   assign rsp_chan.col         = out_col_ff;
   assign rsp_chan.value       = out_value_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.last_of_run = out_last_ff;

endmodule

// ----- design/packed_matrix_index_unpacker_core.sv -----
// ----------------------------------------------------------------------------
// packed_matrix_index_unpacker_core
// Maps a stream of packed edge weights in one of nine explicit matrix
// layouts onto matrix coordinates, flags excess and short streams, and fills
// the zero diagonal after a complete triangle without one.
// ----------------------------------------------------------------------------
// Each weight transaction yields one result, passed from the input register
// to the result register; a new weight is taken every cycle while results
// drain. A final weight ending a short stream adds one flag result, one
// completing a triangle without diagonal adds dim diagonal results. Results
// leave the single result register one per cycle while rsp_chan is ready,
// and the final weight holds the input until the last is loaded. Write the csr
// registers only while the block is idle; any write restarts the stream.
module packed_matrix_index_unpacker_core #(
   parameter int MAX_NODES = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [pmiu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pmiu_pkg::CSR_DATA_W-1:0]  csr_wdata,
   pmiu_req_if.sink                         req_chan,
   pmiu_rsp_if.source                       rsp_chan
);
   import pmiu_pkg::*;

   cfg_type cfg;

   pmiu_cfg #(
      .MAX_NODES (MAX_NODES)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pmiu_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule
